// ===== design/fllt_pkg.sv =====
// Shared types and constants of the failed-login lockout table.
// No dependencies; used by every module of the block.
package fllt_pkg;

    localparam int TABLE_ENTRIES  = 16;
    localparam int KEY_BITS       = 64;
    localparam int TIME_BITS      = 32;
    localparam int DELAY_BITS     = 16;
    localparam int LIMIT_BITS     = 4;
    localparam int CFG_DATA_BITS  = 16;
    localparam int CFG_INDEX_BITS = 1;
    localparam int USED_BITS      = 5;

    localparam logic [CFG_INDEX_BITS-1:0] REG_DELAY_SECONDS = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ATTEMPT_LIMIT = 1'b1;

    localparam logic CMD_FAIL    = 1'b0;
    localparam logic CMD_SUCCESS = 1'b1;

    localparam logic [DELAY_BITS-1:0] DELAY_RESET = 16'd8;
    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 4'd4;

    typedef enum logic [1:0] {
        VERDICT_NONE  = 2'd0,
        VERDICT_LIMIT = 2'd1,
        VERDICT_FULL  = 2'd2
    } verdict_t;

    typedef struct packed {
        logic        cmd;
        logic [63:0] login_key;
        logic [31:0] now_seconds;
    } in_item_t;

    typedef struct packed {
        logic [1:0] verdict;
        logic [4:0] entries_used;
    } out_item_t;

    typedef enum logic [1:0] {
        TOK_NOP,
        TOK_REMOVE,
        TOK_BUMP,
        TOK_ADD
    } tok_op_t;

    // token walking along the row of cells
    typedef struct packed {
        logic     valid;
        tok_op_t  op;
        logic     purge;
        logic     place;
        verdict_t verdict;
    } token_t;

    typedef struct packed {
        logic valid;
        logic match;
        logic stale;
    } cell_stat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOK,
        ST_DECIDE,
        ST_WALK,
        ST_FINISH
    } ctrl_state_t;

endpackage

// ===== design/fllt_cell.sv =====
// One table entry of the lockout table: key, count, last time and valid bit.
// Applies the passing token to its own entry. Depends on fllt_pkg.
module fllt_cell (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          look,
    input  logic [fllt_pkg::KEY_BITS-1:0]   key,
    input  logic [fllt_pkg::TIME_BITS-1:0]  now,
    input  logic [fllt_pkg::DELAY_BITS-1:0] delay,
    input  logic [fllt_pkg::LIMIT_BITS-1:0] limit,
    input  fllt_pkg::token_t              tok_in,
    output fllt_pkg::token_t              tok_out,
    output fllt_pkg::cell_stat_t          stat
);

    logic                          valid_reg, valid_next;
    logic [fllt_pkg::KEY_BITS-1:0]   key_reg, key_next;
    logic [fllt_pkg::LIMIT_BITS-1:0] count_reg, count_next;
    logic [fllt_pkg::TIME_BITS-1:0]  last_reg, last_next;
    logic                          match_reg, match_next;
    logic                          stale_reg, stale_next;
    fllt_pkg::token_t              tok_reg, tok_next;

    logic [fllt_pkg::TIME_BITS-1:0]  age;
    logic [fllt_pkg::LIMIT_BITS-1:0] bump_base;
    logic [fllt_pkg::LIMIT_BITS-1:0] bump_sum;
    logic                          limit_hit;
    logic                          purge_here;

    assign age        = now - last_reg;
    assign bump_base  = stale_reg ? '0 : count_reg;
    assign bump_sum   = bump_base + fllt_pkg::LIMIT_BITS'(1);
    assign limit_hit  = (bump_sum >= limit);
    assign purge_here = tok_in.purge && valid_reg && stale_reg;

    always_comb begin
        valid_next = valid_reg;
        key_next   = key_reg;
        count_next = count_reg;
        last_next  = last_reg;
        match_next = match_reg;
        stale_next = stale_reg;
        tok_next   = tok_in;

        if (look) begin
            match_next = valid_reg && (key_reg == key);
            stale_next = (age >= {{(fllt_pkg::TIME_BITS-fllt_pkg::DELAY_BITS){1'b0}}, delay});
        end

        if (tok_in.valid) begin
            case (tok_in.op)
                fllt_pkg::TOK_REMOVE: begin
                    if (match_reg) begin
                        valid_next = 1'b0;
                    end
                end
                fllt_pkg::TOK_BUMP: begin
                    if (match_reg) begin
                        last_next = now;
                        if (limit_hit) begin
                            count_next       = '0;
                            tok_next.verdict = fllt_pkg::VERDICT_LIMIT;
                        end else begin
                            count_next = bump_sum;
                        end
                    end
                end
                fllt_pkg::TOK_ADD: begin
                    if (purge_here) begin
                        valid_next = 1'b0;
                    end
                    if (tok_in.place && (!valid_reg || purge_here)) begin
                        valid_next     = 1'b1;
                        key_next       = key;
                        count_next     = fllt_pkg::LIMIT_BITS'(1);
                        last_next      = now;
                        tok_next.place = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
            stale_reg <= 1'b0;
            tok_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            match_reg <= match_next;
            stale_reg <= stale_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg   <= key_next;
        count_reg <= count_next;
        last_reg  <= last_next;
    end

    assign tok_out = tok_reg;
    assign stat    = '{valid: valid_reg, match: match_reg, stale: stale_reg};

endmodule

// ===== design/fllt_ctrl.sv =====
// Sequencer of the lockout table: takes an item, samples the cells, launches
// the token along the row and returns the result. Depends on fllt_pkg.
module fllt_ctrl (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    input  logic                                         s_valid,
    output logic                                         s_ready,
    input  fllt_pkg::in_item_t                           s_data,
    output logic                                         m_valid,
    input  logic                                         m_ready,
    output fllt_pkg::out_item_t                          m_data,
    output logic                                         look,
    output logic [fllt_pkg::KEY_BITS-1:0]                req_key,
    output logic [fllt_pkg::TIME_BITS-1:0]               req_now,
    output fllt_pkg::token_t                             tok_launch,
    input  fllt_pkg::token_t                             tok_ret,
    input  fllt_pkg::cell_stat_t [fllt_pkg::TABLE_ENTRIES-1:0] stat
);

    fllt_pkg::ctrl_state_t state_reg, state_next;
    fllt_pkg::in_item_t    req_reg;
    fllt_pkg::verdict_t    verdict_reg;
    logic                  m_valid_reg, m_valid_next;
    fllt_pkg::out_item_t   m_data_reg;

    logic [fllt_pkg::TABLE_ENTRIES-1:0] valid_vec;
    logic [fllt_pkg::TABLE_ENTRIES-1:0] match_vec;
    logic [fllt_pkg::TABLE_ENTRIES-1:0] room_vec;
    logic                               found;
    logic                               full;
    logic                               room;
    logic                               s_accept;
    logic                               out_load;

    always_comb begin
        for (int i = 0; i < fllt_pkg::TABLE_ENTRIES; i++) begin
            valid_vec[i] = stat[i].valid;
            match_vec[i] = stat[i].match;
            room_vec[i]  = !stat[i].valid || stat[i].stale;
        end
    end

    assign found = |match_vec;
    assign full  = &valid_vec;
    assign room  = |room_vec;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            fllt_pkg::ST_IDLE:   if (s_valid) state_next = fllt_pkg::ST_LOOK;
            fllt_pkg::ST_LOOK:   state_next = fllt_pkg::ST_DECIDE;
            fllt_pkg::ST_DECIDE: state_next = fllt_pkg::ST_WALK;
            fllt_pkg::ST_WALK:   if (tok_ret.valid) state_next = fllt_pkg::ST_FINISH;
            fllt_pkg::ST_FINISH: if (!m_valid_reg || m_ready) state_next = fllt_pkg::ST_IDLE;
            default:             state_next = fllt_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready    = 1'b0;
        look       = 1'b0;
        out_load   = 1'b0;
        tok_launch = '{valid: 1'b0, op: fllt_pkg::TOK_NOP, purge: 1'b0, place: 1'b0,
                       verdict: fllt_pkg::VERDICT_NONE};
        unique case (state_reg)
            fllt_pkg::ST_IDLE:   s_ready = 1'b1;
            fllt_pkg::ST_LOOK:   look = 1'b1;
            fllt_pkg::ST_DECIDE: begin
                tok_launch.valid = 1'b1;
                if (req_reg.cmd == fllt_pkg::CMD_SUCCESS) begin
                    tok_launch.op = fllt_pkg::TOK_REMOVE;
                end else if (found) begin
                    tok_launch.op = fllt_pkg::TOK_BUMP;
                end else if (!full) begin
                    tok_launch.op    = fllt_pkg::TOK_ADD;
                    tok_launch.place = 1'b1;
                end else if (room) begin
                    tok_launch.op    = fllt_pkg::TOK_ADD;
                    tok_launch.purge = 1'b1;
                    tok_launch.place = 1'b1;
                end else begin
                    tok_launch.verdict = fllt_pkg::VERDICT_FULL;
                end
            end
            fllt_pkg::ST_WALK:   begin
            end
            fllt_pkg::ST_FINISH: out_load = !m_valid_reg || m_ready;
            default:             begin
            end
        endcase
    end

    assign s_accept = s_valid && s_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= fllt_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            req_reg <= s_data;
        end
        if ((state_reg == fllt_pkg::ST_WALK) && tok_ret.valid) begin
            verdict_reg <= tok_ret.verdict;
        end
        if (out_load) begin
            m_data_reg.verdict      <= verdict_reg;
            m_data_reg.entries_used <= fllt_pkg::USED_BITS'($countones(valid_vec));
        end
    end

    assign req_key = req_reg.login_key[fllt_pkg::KEY_BITS-1:0];
    assign req_now = req_reg.now_seconds;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== design/failed_login_lockout_table_unit.sv =====
// Sequence: the item is registered on the input transfer, the cells are
// sampled, the decision is taken, the token walks through the register of
// every cell in turn and the result is registered towards m_valid.
// One item at a time: a new item is taken once the last result is loaded.
// Reset (aresetn, synchronous): all entries invalid, delay_seconds = 8,
// attempt_limit = 4; no clearing pass. Depends on fllt_pkg, fllt_ctrl, fllt_cell.
module failed_login_lockout_table_unit (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  fllt_pkg::in_item_t                     s_data,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output fllt_pkg::out_item_t                    m_data,
    input  logic                                   cfg_we,
    input  logic [fllt_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [fllt_pkg::CFG_DATA_BITS-1:0]     cfg_wdata
);

    logic [fllt_pkg::DELAY_BITS-1:0] delay_reg, delay_next;
    logic [fllt_pkg::LIMIT_BITS-1:0] limit_reg, limit_next;

    logic                            look;
    logic [fllt_pkg::KEY_BITS-1:0]   req_key;
    logic [fllt_pkg::TIME_BITS-1:0]  req_now;
    fllt_pkg::token_t                tok [fllt_pkg::TABLE_ENTRIES+1];
    fllt_pkg::cell_stat_t [fllt_pkg::TABLE_ENTRIES-1:0] stat_vec;

    always_comb begin
        delay_next = delay_reg;
        limit_next = limit_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                fllt_pkg::REG_DELAY_SECONDS: delay_next = cfg_wdata[fllt_pkg::DELAY_BITS-1:0];
                fllt_pkg::REG_ATTEMPT_LIMIT: limit_next = cfg_wdata[fllt_pkg::LIMIT_BITS-1:0];
                default:                     begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_reg <= fllt_pkg::DELAY_RESET;
            limit_reg <= fllt_pkg::LIMIT_RESET;
        end else begin
            delay_reg <= delay_next;
            limit_reg <= limit_next;
        end
    end

    fllt_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .look       (look),
        .req_key    (req_key),
        .req_now    (req_now),
        .tok_launch (tok[0]),
        .tok_ret    (tok[fllt_pkg::TABLE_ENTRIES]),
        .stat       (stat_vec)
    );

    for (genvar g = 0; g < fllt_pkg::TABLE_ENTRIES; g++) begin : g_cell
        fllt_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .look    (look),
            .key     (req_key),
            .now     (req_now),
            .delay   (delay_reg),
            .limit   (limit_reg),
            .tok_in  (tok[g]),
            .tok_out (tok[g+1]),
            .stat    (stat_vec[g])
        );
    end

endmodule

// ===== design/fllt_checker.sv =====
// Port-level checks of the lockout table, bound to the top level.
// Depends on fllt_pkg and failed_login_lockout_table_unit.
module fllt_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input fllt_pkg::out_item_t m_data
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("result changed while stalled");

    // one item at a time
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken again straight after a transfer");

    a_verdict_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.verdict == fllt_pkg::VERDICT_NONE ||
                     m_data.verdict == fllt_pkg::VERDICT_LIMIT ||
                     m_data.verdict == fllt_pkg::VERDICT_FULL))
        else $error("unknown verdict");

    // table-full verdict only with every entry in use
    a_full_used: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.verdict == fllt_pkg::VERDICT_FULL) |->
        (m_data.entries_used == fllt_pkg::USED_BITS'(fllt_pkg::TABLE_ENTRIES)))
        else $error("table-full verdict with free entries");

endmodule

bind failed_login_lockout_table_unit fllt_checker u_fllt_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ===== dv/tb.sv =====
// Self-checking testbench for failed_login_lockout_table_unit: a queue-fed driver,
// a monitor and a predictor of the slot table, over several register settings.
// Depends on fllt_pkg and the design sources.
`timescale 1ns / 100ps

module tb;

    localparam int STALL_LIMIT = 5000;
    localparam int TAIL_CYCLES = 40;
    localparam int PHASE_ITEMS = 130;
    localparam int POOL_KEYS   = 20;

    logic                                aclk      = 1'b0;
    logic                                aresetn   = 1'b0;
    logic                                s_valid   = 1'b0;
    logic                                s_ready;
    fllt_pkg::in_item_t                  s_data    = '0;
    logic                                m_valid;
    logic                                m_ready   = 1'b0;
    fllt_pkg::out_item_t                 m_data;
    logic                                cfg_we    = 1'b0;
    logic [fllt_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [fllt_pkg::CFG_DATA_BITS-1:0]  cfg_wdata = '0;

    failed_login_lockout_table_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // predictor state
    logic [fllt_pkg::DELAY_BITS-1:0] lock_delay = fllt_pkg::DELAY_RESET;
    logic [fllt_pkg::LIMIT_BITS-1:0] lock_limit = fllt_pkg::LIMIT_RESET;
    logic                            slot_valid [fllt_pkg::TABLE_ENTRIES];
    logic [fllt_pkg::KEY_BITS-1:0]   slot_key   [fllt_pkg::TABLE_ENTRIES];
    logic [3:0]                      slot_count [fllt_pkg::TABLE_ENTRIES];
    logic [fllt_pkg::TIME_BITS-1:0]  slot_stamp [fllt_pkg::TABLE_ENTRIES];

    fllt_pkg::in_item_t  pending_logins[$];
    fllt_pkg::out_item_t expected_outcomes[$];

    int  fail_count   = 0;
    int  stall_cycles = 0;
    bit  steady       = 1'b0;
    logic [fllt_pkg::KEY_BITS-1:0]  key_pool [POOL_KEYS];
    logic [fllt_pkg::TIME_BITS-1:0] wall_clock;

    initial forever #5 aclk = ~aclk;

    function automatic bit slot_aged(int i, logic [fllt_pkg::TIME_BITS-1:0] now_s);
        logic [fllt_pkg::TIME_BITS-1:0] age;
        age = now_s - slot_stamp[i];
        return age >= {16'd0, lock_delay};
    endfunction

    function automatic int occupancy();
        int n;
        n = 0;
        for (int i = 0; i < fllt_pkg::TABLE_ENTRIES; i++) n += slot_valid[i];
        return n;
    endfunction

    function automatic fllt_pkg::out_item_t lockout_predict(fllt_pkg::in_item_t it);
        int                  hit;
        logic [3:0]          cnt;
        fllt_pkg::verdict_t  v;
        fllt_pkg::out_item_t res;
        hit = -1;
        v   = fllt_pkg::VERDICT_NONE;
        for (int i = 0; i < fllt_pkg::TABLE_ENTRIES; i++)
            if (hit < 0 && slot_valid[i] && slot_key[i] == it.login_key) hit = i;
        if (it.cmd == fllt_pkg::CMD_SUCCESS) begin
            if (hit >= 0) slot_valid[hit] = 1'b0;
        end else if (hit >= 0) begin
            if (slot_aged(hit, it.now_seconds)) slot_count[hit] = '0;
            slot_stamp[hit] = it.now_seconds;
            cnt = slot_count[hit] + 4'd1;
            if (cnt >= lock_limit) begin
                cnt = '0;
                v   = fllt_pkg::VERDICT_LIMIT;
            end
            slot_count[hit] = cnt;
        end else begin
            if (occupancy() >= fllt_pkg::TABLE_ENTRIES)
                for (int i = 0; i < fllt_pkg::TABLE_ENTRIES; i++)
                    if (slot_valid[i] && slot_aged(i, it.now_seconds)) slot_valid[i] = 1'b0;
            if (occupancy() >= fllt_pkg::TABLE_ENTRIES) begin
                v = fllt_pkg::VERDICT_FULL;
            end else begin
                hit = -1;
                for (int i = 0; i < fllt_pkg::TABLE_ENTRIES; i++)
                    if (hit < 0 && !slot_valid[i]) hit = i;
                slot_valid[hit] = 1'b1;
                slot_key[hit]   = it.login_key;
                slot_count[hit] = 4'd1;
                slot_stamp[hit] = it.now_seconds;
            end
        end
        res.verdict      = v;
        res.entries_used = fllt_pkg::USED_BITS'(occupancy());
        return res;
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_data  <= '0;
        end else begin
            if (s_valid && s_ready) expected_outcomes.push_back(lockout_predict(s_data));
            if (s_valid && !s_ready) begin
                s_valid <= 1'b1;
            end else if (pending_logins.size() > 0 && (steady || $urandom_range(0, 99) >= 35)) begin
                s_data  <= pending_logins.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        fllt_pkg::out_item_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= steady || $urandom_range(0, 99) >= 35;
            if (m_valid && m_ready) begin
                if (expected_outcomes.size() == 0) begin
                    $error("unexpected result transfer: verdict %0d entries_used %0d",
                           m_data.verdict, m_data.entries_used);
                    fail_count++;
                end else begin
                    want = expected_outcomes.pop_front();
                    if (m_data.verdict !== want.verdict) begin
                        $error("verdict: expected %0d, actual %0d", want.verdict, m_data.verdict);
                        fail_count++;
                    end
                    if (m_data.entries_used !== want.entries_used) begin
                        $error("entries_used: expected %0d, actual %0d",
                               want.entries_used, m_data.entries_used);
                        fail_count++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we || !aresetn)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("tb failed");
        $finish;
    end

    task automatic queue_login(logic cmd, logic [fllt_pkg::KEY_BITS-1:0] key,
                               logic [fllt_pkg::TIME_BITS-1:0] now_s);
        fllt_pkg::in_item_t it;
        it.cmd         = cmd;
        it.login_key   = key;
        it.now_seconds = now_s;
        pending_logins.push_back(it);
    endtask

    task automatic wait_drained();
        do @(negedge aclk);
        while (pending_logins.size() > 0 || s_valid || expected_outcomes.size() > 0);
    endtask

    task automatic write_settings(logic [fllt_pkg::DELAY_BITS-1:0] delay,
                                  logic [fllt_pkg::LIMIT_BITS-1:0] limit);
        logic [fllt_pkg::CFG_DATA_BITS-1:0] limit_word;
        limit_word = {12'($urandom), limit};
        @(posedge aclk);
        cfg_we     <= 1'b1;
        cfg_index  <= fllt_pkg::REG_DELAY_SECONDS;
        cfg_wdata  <= delay;
        lock_delay  = delay;
        @(posedge aclk);
        cfg_index  <= fllt_pkg::REG_ATTEMPT_LIMIT;
        cfg_wdata  <= limit_word;
        lock_limit  = limit_word[fllt_pkg::LIMIT_BITS-1:0];
        @(posedge aclk);
        cfg_we     <= 1'b0;
        cfg_wdata  <= '0;
    endtask

    task automatic queue_random_phase(int n);
        int r;
        logic [fllt_pkg::KEY_BITS-1:0] key;
        for (int i = 0; i < POOL_KEYS; i++) key_pool[i] = {$urandom, $urandom};
        key_pool[0] = '0;
        key_pool[1] = '1;
        wall_clock = $urandom;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < 60)
                wall_clock += $urandom_range(0, 3);
            else if (r < 80)
                wall_clock += lock_delay + $urandom_range(0, 2) - 1;
            else if (r < 92)
                wall_clock += $urandom_range(0, 70000);
            else
                wall_clock = $urandom;
            key = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, POOL_KEYS - 1)]
                                               : {$urandom, $urandom};
            queue_login(($urandom_range(0, 99) < 20) ? fllt_pkg::CMD_SUCCESS
                                                     : fllt_pkg::CMD_FAIL,
                        key, wall_clock);
        end
    endtask

    initial begin
        logic [fllt_pkg::DELAY_BITS-1:0] delays [8] = '{16'd8, 16'd1, 16'd65535, 16'd0,
                                                       16'd3, 16'd200, 16'd65535, 16'd1};
        logic [fllt_pkg::LIMIT_BITS-1:0] limits [8] = '{4'd4, 4'd1, 4'd15, 4'd0,
                                                       4'd2, 4'd6, 4'd1, 4'd15};
        for (int i = 0; i < fllt_pkg::TABLE_ENTRIES; i++) begin
            slot_valid[i] = 1'b0;
            slot_key[i]   = '0;
            slot_count[i] = '0;
            slot_stamp[i] = '0;
        end
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: limit hit, removal, stale restart, full table, purge, wrap
        queue_login(fllt_pkg::CMD_FAIL, '0, 32'd0);
        queue_login(fllt_pkg::CMD_FAIL, '0, 32'd1);
        queue_login(fllt_pkg::CMD_FAIL, '0, 32'd2);
        queue_login(fllt_pkg::CMD_FAIL, '0, 32'd3);
        queue_login(fllt_pkg::CMD_FAIL, '1, 32'd4);
        queue_login(fllt_pkg::CMD_SUCCESS, '1, 32'd5);
        queue_login(fllt_pkg::CMD_SUCCESS, 64'h0123_4567_89ab_cdef, 32'd6);
        queue_login(fllt_pkg::CMD_FAIL, '0, 32'd100);
        for (int i = 1; i <= 15; i++)
            queue_login(fllt_pkg::CMD_FAIL, {$urandom, 32'(i)}, 32'd200);
        queue_login(fllt_pkg::CMD_FAIL, 64'hdead_beef_0000_0001, 32'd201);
        queue_login(fllt_pkg::CMD_FAIL, 64'h8000_0000_0000_0000, 32'hffff_fff8);
        queue_login(fllt_pkg::CMD_FAIL, 64'h8000_0000_0000_0000, 32'd2);
        wait_drained();

        for (int p = 0; p < 8; p++) begin
            repeat (TAIL_CYCLES) @(posedge aclk);
            write_settings(delays[p], limits[p]);
            steady = (p == 3);
            @(negedge aclk);
            queue_random_phase(PHASE_ITEMS);
            wait_drained();
        end
        steady = 1'b0;

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0 && expected_outcomes.size() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/fllt_pkg.sv
design/fllt_cell.sv
design/fllt_ctrl.sv
design/failed_login_lockout_table_unit.sv
design/fllt_checker.sv
dv/tb.sv
